// ===== rtl/core/mm3_pkg.sv =====
// ----------------------------------------------------------------------------
// mm3_pkg
// Shared constants and types for the MurmurHash3 x86_32 hash block.
// ----------------------------------------------------------------------------
package mm3_pkg;

    // Mixing constants
    localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2 = 32'h1b873593;
    localparam logic [31:0] MM_N  = 32'he6546b64;
    localparam logic [31:0] MM_F1 = 32'h85ebca6b;
    localparam logic [31:0] MM_F2 = 32'hc2b2ae35;

    // What the back end does with a mixed key
    typedef logic [1:0] t_op;
    localparam t_op OP_BLOCK = 2'd0;  // xor, rotate, multiply-add
    localparam t_op OP_TAIL  = 2'd1;  // xor only
    localparam t_op OP_NONE  = 2'd2;  // no key

    // Queue entry between front and back
    typedef struct packed {
        logic [31:0] k;      // mixed key
        logic [31:0] len;    // message length, meaningful on the last entry
        t_op         op;
        logic        first;  // first entry of a message: start from the seed
        logic        last;   // finalize and emit
    } t_qent;

endpackage

// ===== rtl/core/mm3_if.sv =====
// ----------------------------------------------------------------------------
// mm3_if
// Valid/ready channels of the hash block: message words, hash results, seed.
// ----------------------------------------------------------------------------
interface mm3_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;

    modport source (output valid, output data_word, output byte_count,
                    output last_word, input ready);
    modport sink   (input valid, input data_word, input byte_count,
                    input last_word, output ready);
endinterface

interface mm3_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

interface mm3_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] wdata;

    modport source (output valid, output wdata, input ready);
    modport sink   (input valid, input wdata, output ready);
endinterface

// ===== rtl/core/murmur3_32_hash.sv =====
// ----------------------------------------------------------------------------
// murmur3_32_hash
// MurmurHash3 x86_32 of a byte message streamed as 32-bit little-endian words.
// ----------------------------------------------------------------------------
// Usage:
//   i_cfg  : seed write channel, always ready; write only while the block is
//            idle. The seed applies from the first word of the next message.
//   i_in   : message words, byte 0 in bits 7:0. Every word before the last is
//            a full block. The last word (last_word = 1) carries byte_count
//            bytes, 0 to 4; counts above four act as four.
//   o_out  : one hash_value transfer per message, after its last word.
// Throughput: one word per cycle while i_in.ready is high; the running hash
//   update in the back end is a combinational xor, rotate and multiply-by-five
//   add, and the front key mix and back finalize multipliers are pipelined,
//   one multiply per stage. Path: the last word passes the key-mix stages,
//   the queue, the hash update, two finalize multiply stages and the output
//   register before its hash is offered.
// Stall: a stalled o_out freezes the finalize pipe; the queue then fills and
//   i_in.ready drops. Non-final words keep draining while the output waits.
// Reset: synchronous, active low; clears the seed to zero, empties the queue
//   and pipes and starts a new message. No clearing pass is needed.
// ----------------------------------------------------------------------------
module murmur3_32_hash
    import mm3_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mm3_in_if.sink     i_in,
    mm3_out_if.source  o_out,
    mm3_cfg_if.sink    i_cfg
);

    // front to queue
    logic  w_push_valid, w_push_ready;
    t_qent w_push_ent;

    // queue to back
    logic  w_pop_valid, w_pop_ready;
    t_qent w_pop_ent;

    // front: accept, count bytes, classify the tail, mix the key
    mm3_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (w_push_valid),
        .o_push_ent   (w_push_ent),
        .i_push_ready (w_push_ready)
    );

    // decouple: the front keeps taking words while the back waits on o_out
    mm3_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_ent   (w_push_ent),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_pop_valid),
        .o_pop_ent    (w_pop_ent),
        .i_pop_ready  (w_pop_ready)
    );

    // back: hash update, length xor, avalanche, output register
    mm3_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_pop_valid (w_pop_valid),
        .i_pop_ent   (w_pop_ent),
        .o_pop_ready (w_pop_ready),
        .o_out       (o_out)
    );

endmodule

// ===== rtl/core/mm3_front.sv =====
// ----------------------------------------------------------------------------
// mm3_front
// Accepts message words, counts bytes, classifies and key-mixes each item.
// ----------------------------------------------------------------------------
module mm3_front
    import mm3_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    mm3_in_if.sink i_in,
    output logic   o_push_valid,
    output t_qent  o_push_ent,
    input  logic   i_push_ready
);

    logic        r_v1, r_v2;
    t_qent       r_s1, r_s2;
    logic        r_in_msg, n_in_msg;
    logic [31:0] r_len, n_len;

    logic        w_adv, w_acc;
    logic [2:0]  w_sat;
    logic [31:0] w_masked, w_len_base, w_len_item;
    t_op         w_op;

    // advance the whole two-stage pipe when its tail can drain
    assign w_adv        = !r_v2 || i_push_ready;
    assign w_acc        = i_in.valid && w_adv;
    assign i_in.ready   = w_adv;
    assign o_push_valid = r_v2;
    assign o_push_ent   = r_s2;

    assign w_sat = (i_in.byte_count > 3'd4) ? 3'd4 : i_in.byte_count;

    always_comb begin
        w_masked = i_in.data_word;
        w_op     = OP_BLOCK;
        if (i_in.last_word) begin
            case (w_sat)
                3'd0:    w_op = OP_NONE;
                3'd4:    w_op = OP_BLOCK;
                default: w_op = OP_TAIL;
            endcase
            case (w_sat)
                3'd1:    w_masked = {24'd0, i_in.data_word[7:0]};
                3'd2:    w_masked = {16'd0, i_in.data_word[15:0]};
                3'd3:    w_masked = {8'd0, i_in.data_word[23:0]};
                default: w_masked = i_in.data_word;
            endcase
        end
    end

    assign w_len_base = r_in_msg ? r_len : 32'd0;
    assign w_len_item = w_len_base + (i_in.last_word ? {29'd0, w_sat} : 32'd4);

    always_comb begin
        n_len    = r_len;
        n_in_msg = r_in_msg;
        if (w_acc) begin
            n_len    = i_in.last_word ? 32'd0 : w_len_item;
            n_in_msg = !i_in.last_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_in_msg <= 1'b0;
            r_len    <= 32'd0;
        end else begin
            r_in_msg <= n_in_msg;
            r_len    <= n_len;
            if (w_adv) begin
                r_v1 <= w_acc;
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1.k     <= w_masked * MM_C1;
            r_s1.len   <= w_len_item;
            r_s1.op    <= w_op;
            r_s1.first <= !r_in_msg;
            r_s1.last  <= i_in.last_word;
            r_s2.k     <= {r_s1.k[16:0], r_s1.k[31:17]} * MM_C2;
            r_s2.len   <= r_s1.len;
            r_s2.op    <= r_s1.op;
            r_s2.first <= r_s1.first;
            r_s2.last  <= r_s1.last;
        end
    end

`ifndef SYNTHESIS
    a_msg_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.last_word) |=> (!r_in_msg && r_len == 32'd0))
        else $error("message state not cleared after last word");
`endif

endmodule

// ===== rtl/core/mm3_queue.sv =====
// ----------------------------------------------------------------------------
// mm3_queue
// Small FIFO of mixed keys between the front and the back.
// ----------------------------------------------------------------------------
module mm3_queue
    import mm3_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    input  t_qent i_push_ent,
    output logic  o_push_ready,
    output logic  o_pop_valid,
    output t_qent o_pop_ent,
    input  logic  i_pop_ready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_qent         r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          w_push, w_pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_ent    = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_count <= r_count + CW'(w_push) - CW'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_ent;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            (r_count == $past(r_count) + CW'($past(w_push)) - CW'($past(w_pop))))
        else $error("queue count out of step with transfers");
`endif

endmodule

// ===== rtl/core/mm3_back.sv =====
// ----------------------------------------------------------------------------
// mm3_back
// Running hash update, seed register and finalization pipeline.
// ----------------------------------------------------------------------------
module mm3_back
    import mm3_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mm3_cfg_if.sink    i_cfg,
    input  logic       i_pop_valid,
    input  t_qent      i_pop_ent,
    output logic       o_pop_ready,
    mm3_out_if.source  o_out
);

    logic [31:0] r_seed;
    logic [31:0] r_hash;
    logic        r_b1_valid, r_b2_valid, r_b3_valid, r_out_valid;
    logic [31:0] r_z, r_m1, r_m2, r_out_hash;

    logic        w_fadv, w_pop;
    logic [31:0] w_h_in, w_hx, w_hr, w_hu, w_h_after;

    assign i_cfg.ready = 1'b1;

    // finalize chain moves as a unit when the output register can drain
    assign w_fadv      = !r_out_valid || o_out.ready;
    assign o_pop_ready = !i_pop_ent.last || w_fadv;
    assign w_pop       = i_pop_valid && o_pop_ready;

    assign o_out.valid      = r_out_valid;
    assign o_out.hash_value = r_out_hash;

    assign w_h_in = i_pop_ent.first ? r_seed : r_hash;
    assign w_hx   = w_h_in ^ i_pop_ent.k;
    assign w_hr   = {w_hx[18:0], w_hx[31:19]};
    assign w_hu   = {w_hr[29:0], 2'b00} + w_hr + MM_N;

    always_comb begin
        case (i_pop_ent.op)
            OP_BLOCK: w_h_after = w_hu;
            OP_TAIL:  w_h_after = w_hx;
            default:  w_h_after = w_h_in;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= 32'd0;
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_b3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_seed <= i_cfg.wdata;
            end
            if (w_fadv) begin
                r_b1_valid  <= w_pop && i_pop_ent.last;
                r_b2_valid  <= r_b1_valid;
                r_b3_valid  <= r_b2_valid;
                r_out_valid <= r_b3_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && !i_pop_ent.last) begin
            r_hash <= w_h_after;
        end
        if (w_fadv) begin
            r_z        <= w_h_after ^ i_pop_ent.len;
            r_m1       <= (r_z ^ {16'd0, r_z[31:16]}) * MM_F1;
            r_m2       <= (r_m1 ^ {13'd0, r_m1[31:13]}) * MM_F2;
            r_out_hash <= r_m2 ^ {16'd0, r_m2[31:16]};
        end
    end

`ifndef SYNTHESIS
    a_hold_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fadv |=> ($stable(r_b3_valid) && $stable(r_out_hash)))
        else $error("finalize stage moved while output stalled");
`endif

endmodule

// ===== test/murmur3_32_hash_tb.sv =====
// ----------------------------------------------------------------------------
// murmur3_32_hash_tb
// Self-checking bench for the MurmurHash3 x86_32 block: a table of directed
// messages and seed writes, then random messages in phases with fresh seeds.
// Every hash transfer is compared against an in-bench model of the hash, or
// against the table digest on rows whose hash is known by inspection.
module murmur3_32_hash_tb;
    import mm3_pkg::*;

    // Bench timing and volume
    localparam int LATENCY_CYCLES = 6;       // base of the settle wait after the last hash
    localparam int SETTLE_CYCLES  = LATENCY_CYCLES + 4;
    localparam int HOLD_CYCLES    = 300;     // long output back-pressure
    localparam int PHASES         = 6;
    localparam int PHASE_WORDS    = 180;
    localparam int TIMEOUT_CYCLES = 400000;

    // One row of the directed table: either a message word or a seed write
    typedef enum logic {
        ROW_WORD,
        ROW_SEED
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [31:0] value;     // data word, or seed for ROW_SEED
        logic [2:0]  count;
        logic        fin;       // last word of the message
        logic        typed;     // hash below is known by inspection
        logic [31:0] digest;
    } t_stim_row;

    localparam int ROWS = 21;

    // Directed walk: extremes, tail lengths, saturated counts, ignored counts
    // on non-final words, empty messages, and a seed write mid-message.
    localparam t_stim_row STIM_TABLE [0:ROWS-1] = '{
        // empty message right after reset: seed 0 finalizes to 0
        '{ROW_WORD, 32'h0000_0000, 3'd0, 1'b1, 1'b1, 32'h0000_0000},
        '{ROW_WORD, 32'hffff_ffff, 3'd4, 1'b1, 1'b0, 32'h0},
        // partial tails: bytes above the count must not leak in
        '{ROW_WORD, 32'hffff_ffff, 3'd1, 1'b1, 1'b0, 32'h0},
        '{ROW_WORD, 32'hffff_ffff, 3'd2, 1'b1, 1'b0, 32'h0},
        '{ROW_WORD, 32'hffff_ffff, 3'd3, 1'b1, 1'b0, 32'h0},
        // counts above four saturate
        '{ROW_WORD, 32'h1234_5678, 3'd5, 1'b1, 1'b0, 32'h0},
        '{ROW_WORD, 32'h9abc_def0, 3'd7, 1'b1, 1'b0, 32'h0},
        '{ROW_SEED, 32'hffff_ffff, 3'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'h0000_0000, 3'd0, 1'b1, 1'b0, 32'h0},
        // byte count ignored on non-final words
        '{ROW_WORD, 32'hffff_ffff, 3'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'h0000_0000, 3'd7, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'h8765_4321, 3'd3, 1'b1, 1'b0, 32'h0},
        '{ROW_SEED, 32'h5082_edee, 3'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'h8765_4321, 3'd4, 1'b1, 1'b0, 32'h0},
        // new seed lands mid-message: the open message keeps the old one
        '{ROW_WORD, 32'ha5a5_a5a5, 3'd6, 1'b0, 1'b0, 32'h0},
        '{ROW_SEED, 32'h0000_0001, 3'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'h5a5a_5a5a, 3'd2, 1'b1, 1'b0, 32'h0},
        '{ROW_WORD, 32'h0000_0000, 3'd0, 1'b1, 1'b0, 32'h0},
        '{ROW_WORD, 32'h0000_0000, 3'd1, 1'b1, 1'b0, 32'h0},
        // length a multiple of four: full word then an empty last word
        '{ROW_WORD, 32'hdead_beef, 3'd4, 1'b0, 1'b0, 32'h0},
        '{ROW_WORD, 32'h0000_0000, 3'd0, 1'b1, 1'b0, 32'h0}
    };

    logic i_clk;
    logic i_rst_n;

    mm3_in_if  word_ch ();
    mm3_out_if hash_ch ();
    mm3_cfg_if seed_ch ();

    murmur3_32_hash i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (word_ch),
        .o_out   (hash_ch),
        .i_cfg   (seed_ch)
    );

    // Hash model state, mirrors what the block holds between words
    logic [31:0] seed_cfg;
    logic [31:0] run_hash;
    logic [31:0] byte_len;
    logic        in_msg;

    logic [31:0] digest_q [$];     // hashes still owed by the block
    int          mismatch_count;
    int          words_sent;

    // Idle control shared with the output side
    bit calm;                      // no idling on either side
    bit short_msgs;                // favor many last words to fill the block
    int hold_asks;                 // requests for a long output hold
    int hold_taken;
    int hold_left;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------------
    // Hash model
    // ------------------------------------------------------------------------
    function automatic logic [31:0] rotate_left(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    // multiply, rotate 15, multiply
    function automatic logic [31:0] scramble_key(input logic [31:0] k);
        logic [31:0] t;
        t = k * MM_C1;
        t = rotate_left(t, 15);
        t = t * MM_C2;
        return t;
    endfunction

    // full block: xor in the key, rotate 13, times five plus constant
    function automatic logic [31:0] fold_block(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] t;
        t = h ^ scramble_key(k);
        t = rotate_left(t, 13);
        return t * 32'd5 + MM_N;
    endfunction

    function automatic logic [31:0] avalanche(input logic [31:0] h, input logic [31:0] len);
        logic [31:0] t;
        t = h ^ len;
        t = t ^ (t >> 16);
        t = t * MM_F1;
        t = t ^ (t >> 13);
        t = t * MM_F2;
        t = t ^ (t >> 16);
        return t;
    endfunction

    // Advance the model by one accepted word; return 1 with the hash when
    // the word closes a message.
    function automatic bit absorb_word(input logic [31:0] w, input logic [2:0] cnt,
                                       input logic fin, output logic [31:0] digest);
        logic [31:0] h;
        logic [2:0]  n;
        logic [31:0] mask;
        digest = '0;
        if (!in_msg) begin
            run_hash = seed_cfg;
            byte_len = '0;
            in_msg   = 1'b1;
        end
        if (!fin) begin
            run_hash = fold_block(run_hash, w);
            byte_len = byte_len + 32'd4;
            return 1'b0;
        end
        n = (cnt > 3'd4) ? 3'd4 : cnt;
        h = run_hash;
        if (n == 3'd4) begin
            h = fold_block(h, w);
        end else if (n != 3'd0) begin
            // keep only the valid tail bytes
            mask = (32'd1 << (8 * int'(n))) - 32'd1;
            h = h ^ scramble_key(w & mask);
        end
        byte_len = byte_len + 32'(n);
        digest   = avalanche(h, byte_len);
        run_hash = '0;
        byte_len = '0;
        in_msg   = 1'b0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: %s: got %08h, want %08h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Sample each hash transfer at the edge; pre-edge values on both sides.
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n && hash_ch.valid && hash_ch.ready) begin
            if (digest_q.size() == 0) begin
                report_mismatch("hash with none pending", hash_ch.hash_value, 32'h0);
            end else begin
                want = digest_q.pop_front();
                if (hash_ch.hash_value !== want) begin
                    report_mismatch("hash_value", hash_ch.hash_value, want);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output side: random back-pressure, plus a long hold on request. The
    // hold is counted here so the sender keeps offering words meanwhile.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hash_ch.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_taken != hold_asks) begin
            hash_ch.ready <= 1'b0;
            hold_taken    <= hold_taken + 1;
            hold_left     <= HOLD_CYCLES;
        end else if (calm) begin
            hash_ch.ready <= 1'b1;
        end else begin
            hash_ch.ready <= ($urandom_range(99) >= 26);
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offer one word, hold it until the transfer, then update the model.
    // Called at a rising edge; returns at the edge of the transfer.
    task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic fin,
                             input logic typed, input logic [31:0] typed_digest);
        logic [31:0] digest;
        while (!calm && $urandom_range(99) < 26) begin
            word_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        word_ch.valid      <= 1'b1;
        word_ch.data_word  <= w;
        word_ch.byte_count <= cnt;
        word_ch.last_word  <= fin;
        @(posedge i_clk);
        while (!word_ch.ready) begin
            @(posedge i_clk);
        end
        if (absorb_word(w, cnt, fin, digest)) begin
            digest_q.push_back(typed ? typed_digest : digest);
        end
        words_sent++;
    endtask

    // Random message: full words with junk counts, then a last word with
    // any count 0..7. Mostly short, now and then long.
    task automatic send_message();
        int n_full;
        if (short_msgs) begin
            n_full = $urandom_range(1);
        end else if ($urandom_range(9) == 0) begin
            n_full = $urandom_range(40, 7);
        end else begin
            n_full = $urandom_range(5);
        end
        for (int k = 0; k < n_full; k++) begin
            send_word($urandom, 3'($urandom_range(7)), 1'b0, 1'b0, 32'h0);
        end
        send_word($urandom, 3'($urandom_range(7)), 1'b1, 1'b0, 32'h0);
    endtask

    // Drop valid, wait for every owed hash, then let the pipe run dry.
    task automatic wait_for_idle();
        word_ch.valid <= 1'b0;
        while (digest_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One seed transfer; the model takes it at the same edge.
    task automatic write_seed(input logic [31:0] value);
        seed_ch.valid <= 1'b1;
        seed_ch.wdata <= value;
        @(posedge i_clk);
        while (!seed_ch.ready) begin
            @(posedge i_clk);
        end
        seed_ch.valid <= 1'b0;
        seed_cfg = value;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int          phase_start;
        logic [31:0] phase_seed;

        // known values on every block input from time zero
        i_rst_n            = 1'b0;
        word_ch.valid      = 1'b0;
        word_ch.data_word  = '0;
        word_ch.byte_count = '0;
        word_ch.last_word  = 1'b0;
        seed_ch.valid      = 1'b0;
        seed_ch.wdata      = '0;
        hash_ch.ready      = 1'b0;
        calm               = 1'b0;
        short_msgs         = 1'b0;
        hold_asks          = 0;
        hold_taken         = 0;
        hold_left          = 0;
        mismatch_count     = 0;
        words_sent         = 0;

        // model after reset
        seed_cfg = '0;
        run_hash = '0;
        byte_len = '0;
        in_msg   = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; seed writes only once the block has gone quiet
        for (int r = 0; r < ROWS; r++) begin
            if (STIM_TABLE[r].kind == ROW_SEED) begin
                wait_for_idle();
                write_seed(STIM_TABLE[r].value);
            end else begin
                send_word(STIM_TABLE[r].value, STIM_TABLE[r].count, STIM_TABLE[r].fin,
                          STIM_TABLE[r].typed, STIM_TABLE[r].digest);
            end
        end

        // Random phases: extreme seeds first, then random ones. Phase 2 runs
        // with no idling; phase 4 holds the output off while short messages
        // keep coming, so the block fills and stalls its input.
        for (int p = 0; p < PHASES; p++) begin
            wait_for_idle();
            if (p == 0) begin
                phase_seed = 32'h0000_0000;
            end else if (p == 1) begin
                phase_seed = 32'hffff_ffff;
            end else begin
                phase_seed = $urandom;
            end
            write_seed(phase_seed);
            calm       = (p == 2);
            short_msgs = (p == 4);
            if (p == 4) begin
                hold_asks++;
            end
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS) begin
                send_message();
            end
        end

        calm       = 1'b0;
        short_msgs = 1'b0;
        wait_for_idle();

        if (mismatch_count == 0) begin
            $display("murmur3_32_hash: match");
        end else begin
            $display("murmur3_32_hash: mismatch");
        end
        $finish;
    end

    // Watchdog: a hung handshake or a missing hash ends the run here
    initial begin
        #(8 * TIMEOUT_CYCLES);
        $display("murmur3_32_hash: mismatch");
        $finish;
    end

endmodule
